>>> sv/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies; used by rau_ctrl, rau_dp and rational_arithmetic_unit_core.
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam logic [2:0] CMD_RED = 3'd5;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       norm;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } rau_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_cmd;
        logic is_cmp;
        logic gcd_done;
    } rau_sts_t;

endpackage

>>> sv/rau_ctrl.sv
// Sequencer for the rational arithmetic unit: multiply, normalize, gcd, divide, output.
// Depends on rau_pkg.
module rau_ctrl #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_cmd_t cmd
);
    import rau_pkg::*;

    localparam int MW = 2 * OPERAND_WIDTH + 2;
    localparam int CW = $clog2(MW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_GINIT = 3'd3;
    localparam logic [2:0] S_GCD   = 3'd4;
    localparam logic [2:0] S_DINIT = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cmd.mul_sel = cnt_reg[1:0];
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.bad_cmd) begin
                    state_next = S_OUT;
                end else begin
                    cmd.mul_en = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    if (cnt_reg[1:0] == 2'd2) begin
                        cnt_next   = '0;
                        state_next = sts.is_cmp ? S_OUT : S_NORM;
                    end
                end
            end
            S_NORM: begin
                cmd.norm   = 1'b1;
                state_next = S_GINIT;
            end
            S_GINIT: begin
                cmd.gcd_init = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD: begin
                if (sts.gcd_done) begin
                    state_next = S_DINIT;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> sv/rau_dp.sv
// Datapath for the rational arithmetic unit: operand fixup, shared multiplier,
// binary gcd and two restoring dividers. Depends on rau_pkg.
module rau_dp #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic [2:0]                    in_cmd,
    input  logic [OPERAND_WIDTH-1:0]      in_num_a,
    input  logic [OPERAND_WIDTH-1:0]      in_den_a,
    input  logic [OPERAND_WIDTH-1:0]      in_num_b,
    input  logic [OPERAND_WIDTH-1:0]      in_den_b,
    input  rau_pkg::rau_cmd_t             cmd,
    output rau_pkg::rau_sts_t             sts,
    output logic [2*OPERAND_WIDTH:0]      res_num,
    output logic [2*OPERAND_WIDTH-2:0]    res_den,
    output logic [1:0]                    order,
    output logic                          fixed_up
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int OW = W + 1;          // operand after negation
    localparam int MW = 2 * W + 2;      // product and magnitude width
    localparam int KW = $clog2(MW + 1);

    localparam logic signed [OW-1:0] ONE  = OW'(1);
    localparam logic signed [OW-1:0] ZERO = '0;

    // operand fixup
    logic signed [OW-1:0] na, da, nb, db, na_c, da_c, nb_c, db_c;
    logic                 bad, da_z, db_z, nb_z;
    logic signed [OW-1:0] a_sel [3];
    logic signed [OW-1:0] b_sel [3];

    always_comb begin
        bad  = (in_cmd > CMD_RED);
        da_z = (in_den_a == '0);
        db_z = (in_den_b == '0) && (in_cmd != CMD_RED);
        nb_z = (in_num_b == '0) && (in_cmd == CMD_DIV);
        na = signed'({in_num_a[W-1], in_num_a});
        da = da_z ? ONE : signed'({in_den_a[W-1], in_den_a});
        nb = nb_z ? ONE : signed'({in_num_b[W-1], in_num_b});
        db = db_z ? ONE : signed'({in_den_b[W-1], in_den_b});
        na_c = da[OW-1] ? -na : na;
        da_c = da[OW-1] ? -da : da;
        nb_c = db[OW-1] ? -nb : nb;
        db_c = db[OW-1] ? -db : db;
        case (in_cmd)
            CMD_ADD, CMD_SUB: begin
                a_sel[0] = na;   b_sel[0] = db;
                a_sel[1] = da;   b_sel[1] = nb;
                a_sel[2] = da;   b_sel[2] = db;
            end
            CMD_MUL: begin
                a_sel[0] = na;   b_sel[0] = nb;
                a_sel[1] = ZERO; b_sel[1] = ZERO;
                a_sel[2] = da;   b_sel[2] = db;
            end
            CMD_DIV: begin
                a_sel[0] = na;   b_sel[0] = db;
                a_sel[1] = ZERO; b_sel[1] = ZERO;
                a_sel[2] = da;   b_sel[2] = nb;
            end
            CMD_CMP: begin
                a_sel[0] = na_c; b_sel[0] = db_c;
                a_sel[1] = nb_c; b_sel[1] = da_c;
                a_sel[2] = ONE;  b_sel[2] = ONE;
            end
            default: begin
                a_sel[0] = na;   b_sel[0] = ONE;
                a_sel[1] = ZERO; b_sel[1] = ZERO;
                a_sel[2] = da;   b_sel[2] = ONE;
            end
        endcase
    end

    logic signed [OW-1:0] a_reg [3];
    logic signed [OW-1:0] b_reg [3];
    logic [2:0]           cmd_reg;
    logic                 fix_reg;
    logic signed [MW-1:0] p_reg [3];
    logic signed [MW-1:0] prod;

    assign prod = MW'(a_reg[cmd.mul_sel] * b_reg[cmd.mul_sel]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg   <= a_sel;
            b_reg   <= b_sel;
            cmd_reg <= in_cmd;
            fix_reg <= !bad && (da_z || db_z || nb_z);
        end
        if (cmd.mul_en) begin
            p_reg[cmd.mul_sel] <= prod;
        end
    end

    // sign to numerator, magnitudes
    logic signed [MW-1:0] sum_w, nn, dd;
    logic        [MW-1:0] n_mag_w;
    logic        [MW-1:0] n_mag_reg, d_mag_reg;
    logic                 neg_reg, zero_reg;

    always_comb begin
        sum_w   = (cmd_reg == CMD_SUB) ? p_reg[0] - p_reg[1] : p_reg[0] + p_reg[1];
        nn      = p_reg[2][MW-1] ? -sum_w : sum_w;
        dd      = p_reg[2][MW-1] ? -p_reg[2] : p_reg[2];
        n_mag_w = nn[MW-1] ? unsigned'(-nn) : unsigned'(nn);
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm) begin
            n_mag_reg <= n_mag_w;
            d_mag_reg <= unsigned'(dd);
            neg_reg   <= nn[MW-1];
            zero_reg  <= (nn == '0);
        end
    end

    // binary gcd, one step per cycle
    logic [MW-1:0] x_reg, y_reg;
    logic [KW-1:0] k_reg;
    logic [MW-1:0] g_w;

    always_ff @(posedge aclk) begin
        if (cmd.gcd_init) begin
            x_reg <= n_mag_reg;
            y_reg <= d_mag_reg;
            k_reg <= '0;
        end else if (cmd.gcd_step) begin
            if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_reg <= (x_reg - y_reg) >> 1;
            end else begin
                y_reg <= (y_reg - x_reg) >> 1;
            end
        end
    end

    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign sts.bad_cmd  = (cmd_reg > CMD_RED);
    assign sts.is_cmp   = (cmd_reg == CMD_CMP);
    // zero numerator keeps gcd one
    assign g_w = zero_reg ? MW'(1) : ((x_reg | y_reg) << k_reg);

    // two restoring dividers sharing the divisor
    logic [MW-1:0] g_reg, qn_reg, qd_reg;
    logic [MW:0]   rn_reg, rd_reg, rn_sh, rd_sh;
    logic          bn, bd;

    always_comb begin
        rn_sh = {rn_reg[MW-1:0], qn_reg[MW-1]};
        rd_sh = {rd_reg[MW-1:0], qd_reg[MW-1]};
        bn    = (rn_sh >= {1'b0, g_reg});
        bd    = (rd_sh >= {1'b0, g_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            g_reg  <= g_w;
            qn_reg <= n_mag_reg;
            qd_reg <= d_mag_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end else if (cmd.div_step) begin
            rn_reg <= bn ? rn_sh - {1'b0, g_reg} : rn_sh;
            rd_reg <= bd ? rd_sh - {1'b0, g_reg} : rd_sh;
            qn_reg <= {qn_reg[MW-2:0], bn};
            qd_reg <= {qd_reg[MW-2:0], bd};
        end
    end

    // result register
    logic [MW-1:0] qn_s;
    assign qn_s = neg_reg ? -qn_reg : qn_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_num  <= '0;
            res_den  <= (2*W-1)'(1);
            order    <= ORD_LT;
            fixed_up <= fix_reg;
            if (cmd_reg == CMD_CMP) begin
                if (p_reg[0] < p_reg[1]) begin
                    order <= ORD_LT;
                end else if (p_reg[0] == p_reg[1]) begin
                    order <= ORD_EQ;
                end else begin
                    order <= ORD_GT;
                end
            end else if (cmd_reg <= CMD_RED) begin
                res_num <= qn_s[2*W:0];
                res_den <= qd_reg[2*W-2:0];
            end else begin
                fixed_up <= 1'b0;
            end
        end
    end

endmodule

>>> sv/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply, divide, compare, reduce.
// Sequence: compare runs the multiply steps, then output; unused codes leave the first
// multiply step for output; others add normalize, gcd loop and divide, and vary with the gcd loop.
// Throughput: one item at a time; s_tready is high only while the sequencer idles,
// so the next item enters at the earliest in the cycle after the result is loaded.
// Reset: aresetn synchronous active low, clears sequencer and m_tvalid. Uses rau_pkg.
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // cmd[2:0], num_a, den_a, num_b, den_b (W bits each), zero pad
    input  logic [((3 + 4*OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // res_num (2W+1), res_den (2W-1), order (2), zero pad
    output logic [((4*OPERAND_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    // fixed_up
    output logic m_tuser
);
    import rau_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int OUT_W = ((4*W + 2 + 7) / 8) * 8;

    rau_cmd_t cmd;
    rau_sts_t sts;

    logic [2*W:0]   res_num;
    logic [2*W-2:0] res_den;
    logic [1:0]     order;
    logic           fixed_up;

    // sequencer: one item in flight
    rau_ctrl #(.OPERAND_WIDTH(W)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: fields unpacked from tdata, lowest field first
    rau_dp #(.OPERAND_WIDTH(W)) u_dp (
        .aclk     (aclk),
        .in_cmd   (s_tdata[2:0]),
        .in_num_a (s_tdata[3 +: W]),
        .in_den_a (s_tdata[3 + W +: W]),
        .in_num_b (s_tdata[3 + 2*W +: W]),
        .in_den_b (s_tdata[3 + 3*W +: W]),
        .cmd      (cmd),
        .sts      (sts),
        .res_num  (res_num),
        .res_den  (res_den),
        .order    (order),
        .fixed_up (fixed_up)
    );

    assign m_tdata = OUT_W'({order, res_den, res_num});
    assign m_tuser = fixed_up;

`ifndef SYNTHESIS
    // reduced denominator is never zero
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_den != '0))
        else $error("zero result denominator");

    // compare results other than LT carry 0/1
    a_cmp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (order != ORD_LT)) |-> ((res_num == '0) && (res_den == (2*W-1)'(1))))
        else $error("compare result not 0/1");

    // no second item taken right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");
`endif

endmodule

>>> test/tb.sv
// Testbench for rational_arithmetic_unit_core: drives random and directed fraction items,
// predicts each reduced result and checks it in order. Depends on rau_pkg and the core.
module tb;
    import rau_pkg::*;

    localparam int W = 16;
    localparam int SW = ((3 + 4*W + 7) / 8) * 8;
    localparam int MW = ((4*W + 2 + 7) / 8) * 8;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [2*W:0]   num;
        logic [2*W-2:0] den;
        logic [1:0]     ord;
        logic           fix;
    } frac_res_t;

    // expected results of accepted items, in arrival order
    class frac_scoreboard;
        frac_res_t pending[$];
        int errors = 0;
        int checked = 0;

        function longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function frac_res_t reduce(longint n, longint d, logic fix);
            frac_res_t r;
            longint unsigned g;
            longint unsigned m;
            if (d < 0) begin
                n = -n;
                d = -d;
            end
            m = (n < 0) ? -n : n;
            g = (n == 0) ? 1 : gcd64(m, d);
            r.num = (2*W+1)'((n < 0) ? -longint'(m / g) : longint'(m / g));
            r.den = (2*W-1)'(d / g);
            r.ord = ORD_LT;
            r.fix = fix;
            return r;
        endfunction

        function void note_item(logic [2:0] op, logic signed [W-1:0] ina,
                                logic signed [W-1:0] ida, logic signed [W-1:0] inb,
                                logic signed [W-1:0] idb);
            longint na, da, nb, db, l, rr;
            logic fix;
            frac_res_t r;
            na = ina; da = ida; nb = inb; db = idb;
            fix = 1'b0;
            r = '0;
            r.den = (2*W-1)'(1);
            if (op > CMD_RED) begin
                pending.insert(pending.size(), r);
                return;
            end
            if (da == 0) begin da = 1; fix = 1'b1; end
            if (op != CMD_RED) begin
                if (db == 0) begin db = 1; fix = 1'b1; end
                if (op == CMD_DIV && nb == 0) begin nb = 1; fix = 1'b1; end
            end
            case (op)
                CMD_ADD: r = reduce(na*db + da*nb, da*db, fix);
                CMD_SUB: r = reduce(na*db - da*nb, da*db, fix);
                CMD_MUL: r = reduce(na*nb, da*db, fix);
                CMD_DIV: r = reduce(na*db, da*nb, fix);
                CMD_CMP: begin
                    if (da < 0) begin na = -na; da = -da; end
                    if (db < 0) begin nb = -nb; db = -db; end
                    l = na*db;
                    rr = nb*da;
                    r.fix = fix;
                    r.ord = (l < rr) ? ORD_LT : (l == rr ? ORD_EQ : ORD_GT);
                end
                default: r = reduce(na, da, fix);
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(frac_res_t got);
            frac_res_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch #%0d: exp num=%0d den=%0d ord=%0d fix=%0b,",
                              " got num=%0d den=%0d ord=%0d fix=%0b"},
                             checked, $signed(e.num), e.den, e.ord, e.fix,
                             $signed(got.num), got.den, got.ord, got.fix);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;
    logic m_tuser;

    frac_scoreboard sb;
    int send_idle = 0;   // percent of cycles the sender idles
    int recv_stall = 0;  // percent of cycles the receiver stalls
    int hold_off = 0;    // cycles of forced receiver hold-off remaining
    int quiet = 0;
    int n_items = 0;

    always #5 aclk = ~aclk;

    rational_arithmetic_unit_core #(.OPERAND_WIDTH(W)) dut (.*);

    // result side: random stall, plus long hold-off when requested
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[2*W:0], m_tdata[4*W-1:2*W+1],
                             m_tdata[4*W+1:4*W], m_tuser});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid stays up between back-to-back items; it drops only in idle cycles
    task automatic send_item(logic [2:0] op, logic [W-1:0] na, logic [W-1:0] da,
                             logic [W-1:0] nb, logic [W-1:0] db);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= SW'({db, nb, da, na, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, na, da, nb, db);
        n_items++;
    endtask

    function automatic logic [W-1:0] rnd_operand();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return W'($urandom_range(15) - 8);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic random_items(int n);
        logic [2:0] op;
        repeat (n) begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(CMD_RED));
            send_item(op, rnd_operand(), rnd_operand(), rnd_operand(), rnd_operand());
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: each command, extremes, zero fix-ups, unused codes
        send_item(CMD_ADD, 1, 2, 1, 3);
        send_item(CMD_SUB, 1, 2, 1, 2);
        send_item(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(CMD_MUL, 16'h8000, 1, 16'h8000, 1);
        send_item(CMD_ADD, 16'h7fff, 1, 16'h7fff, 1);
        send_item(CMD_ADD, 16'h8000, 1, 16'h8000, 1);
        send_item(CMD_DIV, 3, 4, 0, 5);
        send_item(CMD_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_item(CMD_DIV, 6, -4, -9, 2);
        send_item(CMD_CMP, 1, -2, -1, 2);
        send_item(CMD_CMP, 1, 3, 2, 5);
        send_item(CMD_CMP, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_item(CMD_RED, 12, -18, 0, 0);
        send_item(CMD_RED, 0, -7, 5, 0);
        send_item(CMD_RED, 16'h8000, 16'h8000, 1, 1);
        send_item(CMD_ADD, 5, 0, 3, 0);
        send_item(CMD_SUB, 0, 7, 0, 9);
        send_item(3'd6, 1, 1, 1, 1);
        send_item(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        random_items(130);
        send_idle = 64;
        random_items(110);
        send_idle = 0;
        recv_stall = 64;
        random_items(110);
        // long receiver hold-off while the sender keeps offering items
        recv_stall = 0;
        hold_off = 600;
        random_items(40);
        send_idle = 25;
        recv_stall = 25;
        random_items(110);
        send_idle = 0;
        recv_stall = 0;
        random_items(80);
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d items: all six commands, unused codes, zero fix-ups,",
                 n_items);
        $display("operand extremes, idle and stall mixes and a full-stall backpressure stretch.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
